### rtl/core/tskq_pkg.sv
// Shared types, codes and constants of the task ready queue.
// Used by tskq_ctrl, tskq_dpath and task_ready_queue_core; depends on nothing.
package tskq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CFG_IW    = 1;
	localparam int CFG_DW    = 5;

	localparam logic [7:0] EMPTY_TASK = 8'hFF;

	localparam logic [1:0] CMD_ENQ = 2'd0;
	localparam logic [1:0] CMD_DEQ = 2'd1;
	localparam logic [1:0] CMD_CLR = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [CFG_IW-1:0] REG_SCHED_MODE   = 1'd0;
	localparam logic [CFG_IW-1:0] REG_QUEUE_LENGTH = 1'd1;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] task_id;
		logic [7:0] task_priority;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] dequeued_task;
		logic [7:0] head_task;
		logic [4:0] occupancy;
	} result_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_NORM,
		OP_END,
		OP_RD_SCAN,
		OP_CHK,
		OP_RD_SHIFT,
		OP_WR_SHIFT,
		OP_INS,
		OP_RD_HEAD,
		OP_DEQ,
		OP_CLR,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic       norm_ok;
		logic       full;
		logic       empty;
		logic [1:0] command;
		logic       prio_mode;
		logic       hit;
		logic       scan_last;
		logic       shift_last;
		logic       out_free;
	} dp_stat_t;

endpackage

### rtl/core/tskq_ctrl.sv
// Sequencer of the task ready queue: steps one item through normalize, scan,
// shift, insert, remove or clear, head read and result. Depends on tskq_pkg.
module tskq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_take,
	input  tskq_pkg::dp_stat_t  stat,
	output tskq_pkg::dp_cmd_t   cmd,
	output logic                stall
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_END,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS,
		S_DEQ_RD,
		S_DEQ,
		S_CLR,
		S_HEAD_RD,
		S_WAIT,
		S_OUT
	} state_t;

	state_t             state_q;
	tskq_pkg::dp_op_t   op_q;
	logic [1:0]         res_q;
	logic               stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= tskq_pkg::OP_NOP;
			res_q   <= tskq_pkg::ST_DONE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_take) begin
						state_q <= S_NORM;
						op_q    <= tskq_pkg::OP_NORM;
						res_q   <= tskq_pkg::ST_DONE;
						stall_q <= 1'b1;
					end
				end
				S_NORM: begin
					if (stat.norm_ok) begin
						case (stat.command)
							tskq_pkg::CMD_ENQ: begin
								if (stat.full) begin
									res_q   <= tskq_pkg::ST_FULL;
									state_q <= S_HEAD_RD;
									op_q    <= tskq_pkg::OP_RD_HEAD;
								end else begin
									state_q <= S_END;
									op_q    <= tskq_pkg::OP_END;
								end
							end
							tskq_pkg::CMD_DEQ: begin
								if (stat.empty) begin
									res_q   <= tskq_pkg::ST_EMPTY;
									state_q <= S_HEAD_RD;
								end else begin
									state_q <= S_DEQ_RD;
								end
								op_q <= tskq_pkg::OP_RD_HEAD;
							end
							tskq_pkg::CMD_CLR: begin
								state_q <= S_CLR;
								op_q    <= tskq_pkg::OP_CLR;
							end
							default: begin
								state_q <= S_HEAD_RD;
								op_q    <= tskq_pkg::OP_RD_HEAD;
							end
						endcase
					end
				end
				S_END: begin
					if (!stat.prio_mode || stat.empty) begin
						state_q <= S_INS;
						op_q    <= tskq_pkg::OP_INS;
					end else begin
						state_q <= S_SCAN_RD;
						op_q    <= tskq_pkg::OP_RD_SCAN;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CHK;
					op_q    <= tskq_pkg::OP_CHK;
				end
				S_SCAN_CHK: begin
					if (stat.hit) begin
						state_q <= S_SHIFT_RD;
						op_q    <= tskq_pkg::OP_RD_SHIFT;
					end else if (stat.scan_last) begin
						state_q <= S_INS;
						op_q    <= tskq_pkg::OP_INS;
					end else begin
						state_q <= S_SCAN_RD;
						op_q    <= tskq_pkg::OP_RD_SCAN;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
					op_q    <= tskq_pkg::OP_WR_SHIFT;
				end
				S_SHIFT_WR: begin
					if (stat.shift_last) begin
						state_q <= S_INS;
						op_q    <= tskq_pkg::OP_INS;
					end else begin
						state_q <= S_SHIFT_RD;
						op_q    <= tskq_pkg::OP_RD_SHIFT;
					end
				end
				S_INS, S_DEQ, S_CLR: begin
					state_q <= S_HEAD_RD;
					op_q    <= tskq_pkg::OP_RD_HEAD;
				end
				S_DEQ_RD: begin
					state_q <= S_DEQ;
					op_q    <= tskq_pkg::OP_DEQ;
				end
				S_HEAD_RD: begin
					state_q <= S_WAIT;
					op_q    <= tskq_pkg::OP_NOP;
				end
				S_WAIT: begin
					if (stat.out_free) begin
						state_q <= S_OUT;
						op_q    <= tskq_pkg::OP_OUT;
					end
				end
				S_OUT: begin
					state_q <= S_IDLE;
					op_q    <= tskq_pkg::OP_NOP;
					stall_q <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					op_q    <= tskq_pkg::OP_NOP;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign cmd   = '{op: op_q, res_status: res_q};
	assign stall = stall_q;

endmodule

### rtl/core/tskq_dpath.sv
// Datapath of the task ready queue: configuration registers, slot memory with
// valid bits, head and count registers, scan and shift pointers, result register.
// Depends on tskq_pkg.
module tskq_dpath #(
	parameter int DEPTH = tskq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tskq_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [tskq_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          item_take,
	input  tskq_pkg::item_t               item,
	input  tskq_pkg::dp_cmd_t             cmd,
	output tskq_pkg::dp_stat_t            stat,
	input  logic                          out_stall,
	output logic                          out_valid,
	output tskq_pkg::result_t             out_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  sched_mode_q;
	logic [4:0]            queue_length_q;
	logic [CW-1:0]         len;

	logic [15:0]           mem_q [DEPTH];
	logic [DEPTH-1:0]      vld_q;
	logic [15:0]           rd_q;
	logic                  rd_vld_q;

	logic [IW-1:0]         head_q;
	logic [CW-1:0]         cnt_q;
	logic [IW-1:0]         ptr_q;
	logic [IW-1:0]         sp_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         j_q;

	tskq_pkg::item_t       item_q;
	logic [7:0]            deq_q;
	tskq_pkg::result_t     out_q;
	logic                  out_valid_q;

	logic [CW-1:0]         head_c;
	logic [CW:0]           end_sum;
	logic [IW-1:0]         end_ptr;
	logic [IW-1:0]         ptr_prev;
	logic [IW-1:0]         rd_addr;
	logic                  rd_en;
	logic                  wr_en;
	logic [15:0]           wr_data;
	logic [7:0]            rd_task;
	logic                  hit;

	function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p, input logic [CW-1:0] l);
		return (CW'(p) + CW'(1) == l) ? '0 : p + IW'(1);
	endfunction

	function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p, input logic [CW-1:0] l);
		return (p == '0) ? IW'(l - CW'(1)) : p - IW'(1);
	endfunction

	always_comb begin
		if (32'(queue_length_q) > DEPTH) begin
			len = CW'(DEPTH);
		end else if (queue_length_q == 5'd0) begin
			len = CW'(1);
		end else begin
			len = CW'(queue_length_q);
		end
	end

	assign head_c   = CW'(head_q);
	assign end_sum  = (CW + 1)'(head_c) + (CW + 1)'(cnt_q);
	assign end_ptr  = (end_sum >= (CW + 1)'(len)) ? IW'(end_sum - (CW + 1)'(len)) : IW'(end_sum);
	assign ptr_prev = ptr_dec(ptr_q, len);
	assign rd_task  = rd_vld_q ? rd_q[7:0] : tskq_pkg::EMPTY_TASK;
	assign hit      = rd_q[15:8] > item_q.task_priority;

	always_comb begin
		case (cmd.op)
			tskq_pkg::OP_RD_SCAN:  rd_addr = sp_q;
			tskq_pkg::OP_RD_SHIFT: rd_addr = ptr_prev;
			default:               rd_addr = head_q;
		endcase
	end

	assign rd_en   = cmd.op inside {tskq_pkg::OP_RD_SCAN, tskq_pkg::OP_RD_SHIFT,
	                                tskq_pkg::OP_RD_HEAD};
	assign wr_en   = cmd.op inside {tskq_pkg::OP_WR_SHIFT, tskq_pkg::OP_INS};
	assign wr_data = (cmd.op == tskq_pkg::OP_INS) ?
	                 {item_q.task_priority, item_q.task_id} : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[ptr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q     <= mem_q[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_mode_q   <= 1'b1;
			queue_length_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				tskq_pkg::REG_SCHED_MODE:   sched_mode_q   <= cfg_data[0];
				tskq_pkg::REG_QUEUE_LENGTH: queue_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			sp_q        <= '0;
			k_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == tskq_pkg::OP_CLR) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[ptr_q] <= (cmd.op == tskq_pkg::OP_INS) ? 1'b1 : rd_vld_q;
			end
			case (cmd.op)
				tskq_pkg::OP_NORM: begin
					if (head_c >= len) begin
						head_q <= IW'(head_c - len);
					end
					if (cnt_q > len) begin
						cnt_q <= len;
					end
				end
				tskq_pkg::OP_END: begin
					ptr_q <= end_ptr;
					sp_q  <= head_q;
					k_q   <= '0;
					j_q   <= cnt_q;
				end
				tskq_pkg::OP_CHK: begin
					if (!hit) begin
						k_q  <= k_q + CW'(1);
						sp_q <= ptr_inc(sp_q, len);
					end
				end
				tskq_pkg::OP_WR_SHIFT: begin
					ptr_q <= ptr_prev;
					j_q   <= j_q - CW'(1);
				end
				tskq_pkg::OP_INS: begin
					cnt_q <= cnt_q + CW'(1);
				end
				tskq_pkg::OP_DEQ: begin
					head_q <= ptr_inc(head_q, len);
					cnt_q  <= cnt_q - CW'(1);
				end
				tskq_pkg::OP_CLR: begin
					head_q <= '0;
					cnt_q  <= '0;
				end
				default: ;
			endcase
			if (cmd.op == tskq_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_q <= item;
			deq_q  <= tskq_pkg::EMPTY_TASK;
		end else if (cmd.op == tskq_pkg::OP_DEQ) begin
			deq_q <= rd_task;
		end
		if (cmd.op == tskq_pkg::OP_OUT) begin
			out_q.status        <= cmd.res_status;
			out_q.dequeued_task <= deq_q;
			out_q.head_task     <= (cnt_q == '0) ? tskq_pkg::EMPTY_TASK : rd_task;
			out_q.occupancy     <= 5'(cnt_q);
		end
	end

	always_comb begin
		stat.norm_ok    = (head_c < len) && (cnt_q <= len);
		stat.full       = cnt_q >= len;
		stat.empty      = cnt_q == '0;
		stat.command    = item_q.command;
		stat.prio_mode  = sched_mode_q;
		stat.hit        = hit;
		stat.scan_last  = (k_q + CW'(1)) == cnt_q;
		stat.shift_last = j_q == (k_q + CW'(1));
		stat.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/task_ready_queue_core.sv
// Top level of the task ready queue: controller, datapath and configuration port.
// Depends on tskq_pkg, tskq_ctrl and tskq_dpath.
//
// Ready queue of task identifiers in a circular slot memory of programmable
// length (queue_length, clamped to 1..DEPTH; issue a clear after changing it).
// In priority mode (sched_mode 1) an enqueue goes ahead of the first entry with
// a larger priority value, so equal priorities keep FIFO order; in round-robin
// mode it goes to the tail. One command is processed at a time and gives one
// result with status, dequeued task, new head and occupancy. A priority enqueue
// reads and checks entries from the head until one has a larger priority value
// and, if it finds one, shifts the entries from there to the tail by one slot,
// each with a read and a write, as the slot memory takes one access at a time.
// The first command after a length change stays in normalization, subtracting
// the length from the head pointer until it is back in range and clamping the
// count to the new length. An output stall holds a finished command in its
// wait state until the output register is free.
// A result is held in an output register; configuration writes are always
// accepted and must only be issued while the queue is idle.
module task_ready_queue_core #(
	parameter int DEPTH = tskq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tskq_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [tskq_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tskq_pkg::item_t               in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output tskq_pkg::result_t             out_data
);

	tskq_pkg::dp_cmd_t   cmd;
	tskq_pkg::dp_stat_t  stat;
	logic                item_take;
	logic                cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign item_take = in_valid && !in_stall;

	tskq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_take (item_take),
		.stat      (stat),
		.cmd       (cmd),
		.stall     (in_stall)
	);

	tskq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_take (item_take),
		.item      (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_take_then_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> in_stall)
		else $error("input transfer not followed by stall");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.occupancy == 5'd0) |-> out_data.head_task == tskq_pkg::EMPTY_TASK)
		else $error("empty queue reports a head task");

	a_fail_no_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != tskq_pkg::ST_DONE)
		|-> out_data.dequeued_task == tskq_pkg::EMPTY_TASK)
		else $error("failed command reports a dequeued task");

	a_deq_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == tskq_pkg::ST_EMPTY) |-> out_data.occupancy == 5'd0)
		else $error("dequeue on empty with nonzero occupancy");
`endif

endmodule

### sim/task_ready_queue_core_tb.sv
// Testbench of task_ready_queue_core: a directed table, then random phases, one per
// register setting, each transfer checked against a queue predictor or a typed row.
// Depends on tskq_pkg and task_ready_queue_core.
`timescale 1ns / 100ps

module task_ready_queue_core_tb;
	import tskq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int DIR_N = 24;
	localparam int PHASE_N = 12;
	localparam int PHASE_ITEMS = 120;

	typedef struct packed {
		item_t      it;
		logic       typed;
		result_t    res;
	} stim_row_t;

	typedef struct packed {
		logic [CFG_DW-1:0] mode_val;
		logic [CFG_DW-1:0] len_val;
		logic              clr;
		logic [6:0]        idle;
	} phase_t;

	localparam stim_row_t DIR_ROWS [0:DIR_N-1] = '{
		'{'{CMD_DEQ, 8'd0, 8'd0}, 1'b1, '{ST_EMPTY, EMPTY_TASK, EMPTY_TASK, 5'd0}},
		'{'{CMD_NOP, 8'd0, 8'd0}, 1'b1, '{ST_DONE, EMPTY_TASK, EMPTY_TASK, 5'd0}},
		'{'{CMD_CLR, 8'd0, 8'd0}, 1'b1, '{ST_DONE, EMPTY_TASK, EMPTY_TASK, 5'd0}},
		'{'{CMD_ENQ, 8'd0, 8'd0}, 1'b1, '{ST_DONE, EMPTY_TASK, 8'd0, 5'd1}},
		'{'{CMD_ENQ, 8'd254, 8'd255}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd255, 8'd255}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd1, 8'd0}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd170, 8'd128}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd85, 8'd127}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd16, 8'd1}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd32, 8'd2}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd64, 8'd254}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd128, 8'd64}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd200, 8'd8}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd2, 8'd0}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd100, 8'd100}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd101, 8'd100}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd240, 8'd16}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd15, 8'd32}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd77, 8'd0}, 1'b1, '{ST_FULL, EMPTY_TASK, 8'd0, 5'd16}},
		'{'{CMD_DEQ, 8'd0, 8'd0}, 1'b1, '{ST_DONE, 8'd0, 8'd1, 5'd15}},
		'{'{CMD_NOP, 8'd9, 8'd9}, 1'b0, '0},
		'{'{CMD_ENQ, 8'd3, 8'd0}, 1'b0, '0},
		'{'{CMD_CLR, 8'd0, 8'd0}, 1'b1, '{ST_DONE, EMPTY_TASK, EMPTY_TASK, 5'd0}}
	};

	localparam phase_t PHASES [0:PHASE_N-1] = '{
		'{5'd0, 5'd16, 1'b0, 7'd30},
		'{5'd1, 5'd16, 1'b0, 7'd0},
		'{5'd1, 5'd4, 1'b0, 7'd50},
		'{5'd0, 5'd1, 1'b1, 7'd30},
		'{5'd1, 5'd1, 1'b0, 7'd30},
		'{5'd1, 5'd0, 1'b1, 7'd20},
		'{5'd1, 5'd31, 1'b0, 7'd30},
		'{5'd0, 5'd17, 1'b1, 7'd50},
		'{5'd3, 5'd9, 1'b0, 7'd30},
		'{5'd1, 5'd7, 1'b1, 7'd20},
		'{5'd30, 5'd12, 1'b0, 7'd40},
		'{5'd1, 5'd16, 1'b1, 7'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	item_t             in_data;
	logic              out_valid;
	logic              out_stall = 1'b0;
	result_t           out_data;

	logic [7:0]        sim_task [DEPTH];
	logic [7:0]        sim_prio [DEPTH];
	logic [3:0]        sim_head;
	logic [3:0]        sim_tail;
	logic [4:0]        sim_count;
	logic              sim_mode;
	logic [4:0]        sim_qlen;

	result_t           pending_results [$];
	int                errors = 0;
	int                idle_pct = 0;
	int                out_hold = 0;

	task_ready_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t predict_ready_queue(input item_t it);
		int      len;
		int      pos;
		int      k;
		int      dst;
		int      src;
		bit      found;
		result_t r;
		len = (sim_qlen == 5'd0) ? 1 : ((int'(sim_qlen) > DEPTH) ? DEPTH : int'(sim_qlen));
		sim_head = 4'(int'(sim_head) % len);
		sim_tail = 4'(int'(sim_tail) % len);
		if (int'(sim_count) > len)
			sim_count = 5'(len);
		r = '{ST_DONE, EMPTY_TASK, EMPTY_TASK, 5'd0};
		case (it.command)
		CMD_ENQ: begin
			if (int'(sim_count) >= len) begin
				r.status = ST_FULL;
			end else begin
				pos = int'(sim_count);
				if (sim_mode) begin
					found = 1'b0;
					for (k = 0; k < int'(sim_count); k++) begin
						if (!found && sim_prio[(int'(sim_head) + k) % len] > it.task_priority) begin
							pos = k;
							found = 1'b1;
						end
					end
					for (k = int'(sim_count); k > pos; k--) begin
						dst = (int'(sim_head) + k) % len;
						src = (int'(sim_head) + k - 1) % len;
						sim_task[dst] = sim_task[src];
						sim_prio[dst] = sim_prio[src];
					end
				end
				dst = (int'(sim_head) + pos) % len;
				sim_task[dst] = it.task_id;
				sim_prio[dst] = it.task_priority;
				sim_count = sim_count + 5'd1;
				sim_tail = 4'((int'(sim_tail) + 1) % len);
			end
		end
		CMD_DEQ: begin
			if (sim_count == 5'd0) begin
				r.status = ST_EMPTY;
			end else begin
				r.dequeued_task = sim_task[sim_head];
				sim_head = 4'((int'(sim_head) + 1) % len);
				sim_count = sim_count - 5'd1;
			end
		end
		CMD_CLR: begin
			for (k = 0; k < DEPTH; k++)
				sim_task[k] = EMPTY_TASK;
			sim_head = '0;
			sim_tail = '0;
			sim_count = '0;
		end
		default: begin
		end
		endcase
		r.head_task = (sim_count == 5'd0) ? EMPTY_TASK : sim_task[sim_head];
		r.occupancy = sim_count;
		return r;
	endfunction

	function automatic item_t random_item(input int enq_pct);
		item_t it;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 2)
			it.command = CMD_CLR;
		else if (r < 4)
			it.command = CMD_NOP;
		else if (r < 4 + enq_pct * 96 / 100)
			it.command = CMD_ENQ;
		else
			it.command = CMD_DEQ;
		it.task_id = ($urandom_range(0, 39) == 0) ? EMPTY_TASK : 8'($urandom_range(0, 254));
		it.task_priority = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) :
			8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
		int      gap;
		result_t r;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		r = predict_ready_queue(it);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SCHED_MODE)
			sim_mode = val[0];
		else
			sim_qlen = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_hold--;
			out_stall <= 1'b1;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
			out_hold = $urandom_range(1, 13) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: transfer expected none actual %h", $time, out_data);
			end else begin
				want = pending_results.pop_front();
				check_field("status", int'(want.status), int'(out_data.status));
				check_field("dequeued_task", int'(want.dequeued_task),
					int'(out_data.dequeued_task));
				check_field("head_task", int'(want.head_task), int'(out_data.head_task));
				check_field("occupancy", int'(want.occupancy), int'(out_data.occupancy));
			end
		end
	end

	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int p;
		int n;
		int enq_pct;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		for (n = 0; n < DEPTH; n++) begin
			sim_task[n] = EMPTY_TASK;
			sim_prio[n] = '0;
		end
		sim_head = '0;
		sim_tail = '0;
		sim_count = '0;
		sim_mode = 1'b1;
		sim_qlen = 5'd16;
		enq_pct = 50;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 30;
		for (n = 0; n < DIR_N; n++)
			send_item(DIR_ROWS[n].it, DIR_ROWS[n].typed, DIR_ROWS[n].res);

		for (p = 0; p < PHASE_N; p++) begin
			@(negedge clk);
			in_valid <= 1'b0;
			wait_drained();
			cfg_write(REG_SCHED_MODE, PHASES[p].mode_val);
			cfg_write(REG_QUEUE_LENGTH, PHASES[p].len_val);
			idle_pct = int'(PHASES[p].idle);
			if (PHASES[p].clr)
				send_item('{CMD_CLR, 8'd0, 8'd0}, 1'b0, '0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// drift between filling and draining so both full and empty are hit
				if (n % 30 == 0)
					enq_pct = 25 * $urandom_range(1, 3);
				send_item(random_item(enq_pct), 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
